>>> rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and codes for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  // what the unit itself turns into
  typedef logic [2:0] kind_t;

  localparam kind_t KIND_NONE  = 3'd0;  // nothing of its own (new high surrogate)
  localparam kind_t KIND_ZERO  = 3'd1;  // terminating zero byte
  localparam kind_t KIND_ONE   = 3'd2;  // ASCII, one byte
  localparam kind_t KIND_TWO   = 3'd3;  // two-byte sequence
  localparam kind_t KIND_THREE = 3'd4;  // three-byte sequence
  localparam kind_t KIND_PAIR  = 3'd5;  // surrogate pair, four bytes

  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // one queue entry: optional flush of a held high surrogate, then the unit
  typedef struct packed {
    logic        flush;      // emit held high surrogate as three bytes first
    logic [9:0]  held_bits;  // low ten bits of the held high surrogate
    kind_t       kind;
    logic [15:0] unit;
  } job_t;

endpackage

>>> rtl/utf16_to_utf8_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out.
// ----------------------------------------------------------------------------
// Each transaction on the slave side carries one UTF-16 code unit; each
// transaction on the master side carries one UTF-8 byte, with tlast on the
// final byte caused by that unit and tuser on the terminating zero byte that
// a zero unit produces. A high surrogate is held until the next unit: a low
// surrogate completes a four-byte sequence, anything else first flushes the
// held unit as three bytes. The output runs at one byte per cycle while
// m_tready allows it; a unit gives one to three bytes, four for the low half
// of a completed pair and none for a fresh high surrogate (up to six when a
// held unit is flushed ahead of a three-byte unit); the byte sequencer in
// the back end sets those byte counts. Units are taken every cycle while the
// job queue (QUEUE_DEPTH entries) has room, and a byte waiting in the output
// register does not stop the front end.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top
  import u16u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // [0] string_end
);

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  // front: classify and track held surrogate
  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (s_tvalid),
    .unit_ready (s_tready),
    .unit       (s_tdata),
    .queue_full (full),
    .push       (push),
    .job        (push_job)
  );

  // decoupling queue
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // back: byte sequencer and output register
  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .byte_valid (m_tvalid),
    .byte_ready (m_tready),
    .out_byte   (m_tdata),
    .run_last   (m_tlast),
    .string_end (m_tuser)
  );

  // terminator is always a zero byte closing its run
  a_end_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("string end on non-zero or non-final byte");

  // a lead byte of a multi-byte sequence never closes a run
  a_lead_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:6] == 2'b11) |-> !m_tlast)
    else $error("run closed on a lead byte");

endmodule

>>> rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks a held high surrogate and classifies each unit
// into a job for the queue.
// ----------------------------------------------------------------------------
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_valid,
  output logic        unit_ready,
  input  logic [15:0] unit,
  input  logic        queue_full,
  output logic        push,
  output job_t        job
);

  logic       held_valid;
  logic [9:0] held_bits;
  logic       is_high;
  logic       is_low;
  logic       take;

  assign is_high    = (unit[15:10] == HIGH_SURR_TAG);
  assign is_low     = (unit[15:10] == LOW_SURR_TAG);
  assign unit_ready = !queue_full;
  assign take       = unit_valid && unit_ready;

  always_comb begin
    job.held_bits = held_bits;
    job.unit      = unit;
    if (held_valid && is_low) begin
      job.flush = 1'b0;
      job.kind  = KIND_PAIR;
    end else begin
      job.flush = held_valid;
      if (unit == 16'd0) begin
        job.kind = KIND_ZERO;
      end else if (unit[15:7] == 9'd0) begin
        job.kind = KIND_ONE;
      end else if (unit[15:11] == 5'd0) begin
        job.kind = KIND_TWO;
      end else if (is_high) begin
        job.kind = KIND_NONE;
      end else begin
        job.kind = KIND_THREE;
      end
    end
  end

  // a fresh high surrogate with nothing held makes no job
  assign push = take && (held_valid || !is_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= is_high;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_high) begin
      held_bits <= unit[9:0];
    end
  end

endmodule

>>> rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> count == FULL_CNT)
    else $error("queue lost an entry while full");

endmodule

>>> rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Expands queued jobs into UTF-8 bytes, one per cycle while byte_ready allows,
// into an output register.
// ----------------------------------------------------------------------------
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  logic [2:0]  idx;
  logic [2:0]  own_cnt;
  logic [2:0]  total;
  logic [2:0]  own_idx;
  logic        in_flush;
  logic        load;
  logic        is_last;
  logic [15:0] held_unit;
  logic [4:0]  plane;
  logic [20:0] cp;
  logic [7:0]  byte_next;
  logic        end_next;

  assign held_unit = {HIGH_SURR_TAG, head.held_bits};
  // code point of the pair: plane field is bits [9:6] of the high surrogate plus one
  assign plane     = {1'b0, head.held_bits[9:6]} + 5'd1;
  assign cp        = {plane, head.held_bits[5:0], head.unit[9:0]};

  always_comb begin
    case (head.kind)
      KIND_ZERO:  own_cnt = 3'd1;
      KIND_ONE:   own_cnt = 3'd1;
      KIND_TWO:   own_cnt = 3'd2;
      KIND_THREE: own_cnt = 3'd3;
      KIND_PAIR:  own_cnt = 3'd4;
      default:    own_cnt = 3'd0;
    endcase
  end

  assign total    = own_cnt + (head.flush ? 3'd3 : 3'd0);
  assign in_flush = head.flush && (idx < 3'd3);
  assign own_idx  = head.flush ? idx - 3'd3 : idx;
  assign is_last  = (idx == total - 3'd1);

  always_comb begin
    end_next  = 1'b0;
    byte_next = 8'd0;
    if (in_flush) begin
      case (idx[1:0])
        2'd0:    byte_next = {4'hE, held_unit[15:12]};
        2'd1:    byte_next = {2'b10, held_unit[11:6]};
        default: byte_next = {2'b10, held_unit[5:0]};
      endcase
    end else begin
      case (head.kind)
        KIND_ZERO: begin
          byte_next = 8'd0;
          end_next  = 1'b1;
        end
        KIND_ONE: begin
          byte_next = head.unit[7:0];
        end
        KIND_TWO: begin
          byte_next = (own_idx == 3'd0) ? {3'b110, head.unit[10:6]}
                                        : {2'b10, head.unit[5:0]};
        end
        KIND_THREE: begin
          case (own_idx)
            3'd0:    byte_next = {4'hE, head.unit[15:12]};
            3'd1:    byte_next = {2'b10, head.unit[11:6]};
            default: byte_next = {2'b10, head.unit[5:0]};
          endcase
        end
        KIND_PAIR: begin
          case (own_idx)
            3'd0:    byte_next = {5'b11110, cp[20:18]};
            3'd1:    byte_next = {2'b10, cp[17:12]};
            3'd2:    byte_next = {2'b10, cp[11:6]};
            default: byte_next = {2'b10, cp[5:0]};
          endcase
        end
        default: begin
          byte_next = 8'd0;
        end
      endcase
    end
  end

  assign load = !empty && (!byte_valid || byte_ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 3'd0;
      byte_valid <= 1'b0;
    end else begin
      if (load) begin
        idx        <= is_last ? 3'd0 : idx + 3'd1;
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= byte_next;
      run_last   <= is_last;
      string_end <= end_next;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx < total)
    else $error("byte index past end of job");

endmodule
